### src/srr_pkg.sv
// Shared types, constants and the quarter-wave sine table for the speed reversal ramp.
`default_nettype none

package srr_pkg;

	localparam int TRIG_TABLE_BITS = 10;
	localparam int TRIG_N          = 1 << TRIG_TABLE_BITS;
	localparam int PHASE_W         = TRIG_TABLE_BITS + 1;
	localparam int STEP_W          = $clog2(PHASE_W + 1);
	localparam int TRIG_W          = 15;
	localparam int SPEED_W         = 16;
	localparam int CMD_W           = 17;
	localparam int PROD_W          = TRIG_W + SPEED_W;
	localparam int CFG_IDX_W       = 3;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [1:0]         dir_t;
	typedef logic [SPEED_W-1:0]        speed_t;
	typedef logic signed [CMD_W-1:0]   cmd_t;
	typedef logic [PHASE_W-1:0]        phase_t;
	typedef logic [TRIG_W-1:0]         trig_t;
	typedef logic [STEP_W-1:0]         step_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [PROD_W-1:0]         prod_t;
	typedef trig_t                     sine_rom_t [0:TRIG_N];

	localparam dir_t DIR_STOP = 2'sb00;
	localparam dir_t DIR_FWD  = 2'sb01;
	localparam dir_t DIR_REV  = 2'sb11;

	localparam cfg_idx_t CFG_SLOW_CODE    = 3'd0;
	localparam cfg_idx_t CFG_MIDDLE_CODE  = 3'd1;
	localparam cfg_idx_t CFG_FAST_CODE    = 3'd2;
	localparam cfg_idx_t CFG_SLOW_TICKS   = 3'd3;
	localparam cfg_idx_t CFG_MIDDLE_TICKS = 3'd4;
	localparam cfg_idx_t CFG_FAST_TICKS   = 3'd5;

	localparam speed_t RST_SLOW_CODE    = 16'd1000;
	localparam speed_t RST_MIDDLE_CODE  = 16'd2000;
	localparam speed_t RST_FAST_CODE    = 16'd3000;
	localparam speed_t RST_SLOW_TICKS   = 16'd400;
	localparam speed_t RST_MIDDLE_TICKS = 16'd200;
	localparam speed_t RST_FAST_TICKS   = 16'd150;

	localparam phase_t TRIG_N_P = PHASE_W'(TRIG_N);

	typedef struct packed {
		logic   start;
		logic   cos_mode;
		speed_t numer;
		speed_t denom;
	} div_req_t;

	typedef struct packed {
		logic   done;
		phase_t quot;
	} div_rsp_t;

	// Shift-subtract long division, used only while building the table.
	function automatic longint unsigned long_divide(input longint unsigned numer,
			input longint unsigned denom);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], numer[b]};
			if (rem >= denom) begin
				rem    = rem - denom;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Q30 Taylor series to x^15, scaled to Q15 with round half up.
	function automatic trig_t sine_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		longint unsigned q;
		x    = (longint'(k) * HALF_PI_Q30) / TRIG_N;
		term = x;
		sum  = longint'(x);
		for (int i = 1; i <= 7; i++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = long_divide(term, 64'((2 * i) * (2 * i + 1)));
			if (i % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		q = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (q > 64'd32767)
			q = 64'd32767;
		return TRIG_W'(q);
	endfunction

	function automatic sine_rom_t build_sine_table();
		sine_rom_t t;
		for (int k = 0; k <= TRIG_N; k++)
			t[k] = sine_entry(k);
		return t;
	endfunction

	localparam sine_rom_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

### src/srr_if.sv
// Channel interfaces: input item, result item and configuration write.
`default_nettype none

interface srr_in_if;
	import srr_pkg::*;
	logic   valid;
	logic   ready;
	dir_t   wanted_direction;
	speed_t speed_magnitude;
	modport source (output valid, output wanted_direction, output speed_magnitude, input ready);
	modport sink (input valid, input wanted_direction, input speed_magnitude, output ready);
endinterface

interface srr_out_if;
	import srr_pkg::*;
	logic valid;
	logic ready;
	cmd_t speed_command;
	logic ramp_active;
	modport source (output valid, output speed_command, output ramp_active, input ready);
	modport sink (input valid, input speed_command, input ramp_active, output ready);
endinterface

interface srr_cfg_if;
	import srr_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	speed_t   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/srr_divider.sv
// Restoring divider giving the ramp phase index, one quotient bit per cycle.
`default_nettype none

module srr_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srr_pkg::div_req_t req,
	output srr_pkg::div_rsp_t      rsp
);
	import srr_pkg::*;

	logic   busy_q;
	step_t  steps_q;
	speed_t rem_q;
	speed_t den_q;
	phase_t quot_q;

	logic [SPEED_W:0] shifted;
	logic             fits;

	// Numerator is below the divisor, so the remainder stays within 16 bits.
	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			steps_q <= req.cos_mode ? STEP_W'(PHASE_W) : STEP_W'(TRIG_TABLE_BITS);
		end else if (busy_q) begin
			steps_q <= steps_q - 1'b1;
			if (steps_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.numer;
			den_q  <= req.denom;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? SPEED_W'(shifted - {1'b0, den_q}) : SPEED_W'(shifted);
			quot_q <= {quot_q[PHASE_W-2:0], fits};
		end
	end

	assign rsp.done = busy_q && (steps_q == STEP_W'(1));
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

### src/srr_sine_rom.sv
// Quarter-wave Q15 sine ROM with registered read data.
`default_nettype none

module srr_sine_rom (
	input  wire logic            clk,
	input  wire srr_pkg::phase_t addr,
	output srr_pkg::trig_t       data
);
	import srr_pkg::*;

	trig_t data_q;

	always_ff @(posedge clk) begin
		data_q <= SINE_TABLE[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

### src/speed_reversal_ramp.sv
// Accepted item on the direct path: evaluate and finish states, then a result held in the output register.
// Ramp ticks: the divider takes one phase bit per cycle (10 for sine, 11 for cosine),
// then the table read, multiply and result steps follow in that order.
// A new item is taken once the sequencer is back in idle, later while a waiting
// result blocks the output register.
// Reset (arst_n low, asynchronous): configuration registers to their default values, settled
// direction to standstill, tick count to zero, output register empty.
`default_nettype none

module speed_reversal_ramp (
	input  wire logic   clk,
	input  wire logic   arst_n,
	srr_in_if.sink      cmd_in,
	srr_out_if.source   cmd_out,
	srr_cfg_if.sink     cfg
);
	import srr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ROM  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;

	speed_t slow_code_q, middle_code_q, fast_code_q;
	speed_t slow_ticks_q, middle_ticks_q, fast_ticks_q;

	dir_t   settled_q;
	speed_t count_q;
	dir_t   dir_q;
	speed_t speed_q;
	speed_t len_q;
	logic   ramp_q;
	logic   neg_q;
	prod_t  prod_q;

	logic   out_valid_q;
	cmd_t   out_cmd_q;
	logic   out_active_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	phase_t   rom_addr;
	trig_t    rom_data;

	logic   in_fire;
	dir_t   dir_norm;
	speed_t len_sel;
	speed_t cnt_inc;
	logic   changing;
	logic   in_ramp;
	logic   cos_mode;
	logic   out_free;
	speed_t mag;
	cmd_t   ramp_cmd;
	cmd_t   direct_cmd;

	assign in_fire = cmd_in.valid && cmd_in.ready;
	assign cmd_in.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// Reverse covers both negative codes.
	always_comb begin
		if (cmd_in.wanted_direction == DIR_STOP)
			dir_norm = DIR_STOP;
		else if (cmd_in.wanted_direction == DIR_FWD)
			dir_norm = DIR_FWD;
		else
			dir_norm = DIR_REV;
	end

	always_comb begin
		if (cmd_in.speed_magnitude == slow_code_q)
			len_sel = slow_ticks_q;
		else if (cmd_in.speed_magnitude == middle_code_q)
			len_sel = middle_ticks_q;
		else
			len_sel = fast_ticks_q;
	end

	assign cnt_inc  = count_q + 1'b1;
	assign changing = dir_q != settled_q;
	assign in_ramp  = cnt_inc < len_q;
	assign cos_mode = settled_q != DIR_STOP;

	assign div_req.start    = (state_q == ST_EVAL) && changing && in_ramp;
	assign div_req.cos_mode = cos_mode;
	assign div_req.numer    = cnt_inc;
	assign div_req.denom    = len_q;

	srr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Cosine folds onto the quarter wave: past the midpoint it reads the mirror, negated.
	always_comb begin
		if (!cos_mode)
			rom_addr = div_rsp.quot;
		else if (div_rsp.quot <= TRIG_N_P)
			rom_addr = TRIG_N_P - div_rsp.quot;
		else
			rom_addr = div_rsp.quot - TRIG_N_P;
	end

	srr_sine_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign mag      = prod_q[PROD_W-1:TRIG_W];
	assign ramp_cmd = neg_q ? -cmd_t'({1'b0, mag}) : cmd_t'({1'b0, mag});

	always_comb begin
		if (dir_q == DIR_FWD)
			direct_cmd = cmd_t'({1'b0, speed_q});
		else if (dir_q == DIR_REV)
			direct_cmd = -cmd_t'({1'b0, speed_q});
		else
			direct_cmd = '0;
	end

	assign out_free = !out_valid_q || cmd_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_code_q    <= RST_SLOW_CODE;
			middle_code_q  <= RST_MIDDLE_CODE;
			fast_code_q    <= RST_FAST_CODE;
			slow_ticks_q   <= RST_SLOW_TICKS;
			middle_ticks_q <= RST_MIDDLE_TICKS;
			fast_ticks_q   <= RST_FAST_TICKS;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SLOW_CODE:    slow_code_q    <= cfg.data;
				CFG_MIDDLE_CODE:  middle_code_q  <= cfg.data;
				CFG_FAST_CODE:    fast_code_q    <= cfg.data;
				CFG_SLOW_TICKS:   slow_ticks_q   <= cfg.data;
				CFG_MIDDLE_TICKS: middle_ticks_q <= cfg.data;
				CFG_FAST_TICKS:   fast_ticks_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			settled_q   <= DIR_STOP;
			count_q     <= '0;
			ramp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result, else drop the one just taken.
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && cmd_out.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (changing) begin
						if (in_ramp) begin
							count_q <= cnt_inc;
							ramp_q  <= 1'b1;
							state_q <= ST_DIV;
						end else begin
							settled_q <= dir_q;
							count_q   <= '0;
							ramp_q    <= 1'b0;
							state_q   <= ST_FIN;
						end
					end else begin
						ramp_q  <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_rsp.done)
						state_q <= ST_ROM;
				end
				ST_ROM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// Hold until the output register can take the result.
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			dir_q   <= dir_norm;
			speed_q <= cmd_in.speed_magnitude;
			len_q   <= len_sel;
		end
		if (state_q == ST_ROM)
			neg_q <= cos_mode ? ((settled_q == DIR_REV) ^ (div_rsp.quot > TRIG_N_P))
			                  : (dir_q == DIR_REV);
		if (state_q == ST_MUL)
			prod_q <= PROD_W'(rom_data) * PROD_W'(speed_q);
		if (state_q == ST_FIN && out_free) begin
			out_cmd_q    <= ramp_q ? ramp_cmd : direct_cmd;
			out_active_q <= ramp_q;
		end
	end

	assign cmd_out.valid         = out_valid_q;
	assign cmd_out.speed_command = out_cmd_q;
	assign cmd_out.ramp_active   = out_active_q;

endmodule

`default_nettype wire
